### design/ffa_pkg.sv
`default_nettype none
package ffa_pkg;

	localparam int unsigned POOL_WORDS_DEF  = 65536;
	localparam int unsigned MAX_EXTENTS_DEF = 64;
	localparam int unsigned ADDR_W          = 16;
	localparam int unsigned LEN_W           = 17;
	localparam int unsigned OP_W            = 1;
	localparam int unsigned STATUS_W        = 2;
	localparam logic [LEN_W-1:0] LEN_MAX    = 17'h1FFFF;
	localparam logic [LEN_W-1:0] POOL_RESET = 17'h10000;

	localparam logic [OP_W-1:0] OP_ALLOC   = 1'b0;
	localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OOM  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic hdr_rd;
		logic hdr_lat;
		logic rd_en;
		logic ptr_inc;
		logic ptr_dec;
		logic scan;
		logic alc_dec;
		logic rel_dec;
		logic rem_wr;
		logic ins_wr;
		logic ins_fin;
		logic cnt_dec;
		logic hdr_wr;
		logic finish;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic op;
		logic stored;
		logic vld_s1;
		logic stop;
		logic more_up;
		logic more_dn;
		logic hit;
		logic whole;
		logic oom;
		logic join_lo;
		logic join_hi;
		logic full;
		logic out_busy;
	} stat_t;

	function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W+1:0] v);
		if (v > {2'b00, LEN_MAX}) begin
			return LEN_MAX;
		end
		return v[LEN_W-1:0];
	endfunction

endpackage
`default_nettype wire

### design/ffa_ctrl.sv
`default_nettype none
module ffa_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  ffa_pkg::stat_t   stat,
	output ffa_pkg::cmd_t    cmd
);
	import ffa_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_HDR  = 11'b00000000010,
		S_HDRW = 11'b00000000100,
		S_SCAN = 11'b00000001000,
		S_ADEC = 11'b00000010000,
		S_RDEC = 11'b00000100000,
		S_REM  = 11'b00001000000,
		S_INS  = 11'b00010000000,
		S_INSW = 11'b00100000000,
		S_HWR  = 11'b01000000000,
		S_FIN  = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					// a stored release goes through the header read first
					state_d  = (stat.op == OP_RELEASE && stat.stored) ? S_HDR : S_SCAN;
				end
			end
			S_HDR: begin
				cmd.hdr_rd = 1'b1;
				state_d    = S_HDRW;
			end
			S_HDRW: begin
				cmd.hdr_lat = 1'b1;
				state_d     = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.stop) begin
					state_d = (stat.op == OP_RELEASE) ? S_RDEC : S_ADEC;
				end else if (stat.more_up) begin
					cmd.rd_en   = 1'b1;
					cmd.ptr_inc = 1'b1;
				end else if (!stat.vld_s1) begin
					state_d = (stat.op == OP_RELEASE) ? S_RDEC : S_ADEC;
				end
			end
			S_ADEC: begin
				cmd.alc_dec = 1'b1;
				if (stat.oom) begin
					state_d = S_FIN;
				end else if (stat.hit && stat.whole) begin
					state_d = S_REM;
				end else begin
					state_d = stat.stored ? S_HWR : S_FIN;
				end
			end
			S_RDEC: begin
				cmd.rel_dec = 1'b1;
				if (stat.join_lo && stat.join_hi) begin
					state_d = S_REM;
				end else if (stat.join_lo || stat.join_hi || stat.full) begin
					state_d = S_FIN;
				end else begin
					state_d = S_INS;
				end
			end
			S_REM: begin
				cmd.rem_wr = stat.vld_s1;
				if (stat.more_up) begin
					cmd.rd_en   = 1'b1;
					cmd.ptr_inc = 1'b1;
				end else if (!stat.vld_s1) begin
					cmd.cnt_dec = 1'b1;
					state_d = (stat.op == OP_ALLOC && stat.stored) ? S_HWR : S_FIN;
				end
			end
			S_INS: begin
				cmd.ins_wr = stat.vld_s1;
				if (stat.more_dn) begin
					cmd.rd_en   = 1'b1;
					cmd.ptr_dec = 1'b1;
				end else if (!stat.vld_s1) begin
					state_d = S_INSW;
				end
			end
			S_INSW: begin
				cmd.ins_fin = 1'b1;
				state_d     = S_FIN;
			end
			S_HWR: begin
				cmd.hdr_wr = 1'b1;
				state_d    = S_FIN;
			end
			S_FIN: begin
				if (!stat.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

### design/ffa_dp.sv
`default_nettype none
module ffa_dp #(
	parameter int unsigned POOL_WORDS  = ffa_pkg::POOL_WORDS_DEF,
	parameter int unsigned MAX_EXTENTS = ffa_pkg::MAX_EXTENTS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  ffa_pkg::cmd_t                    cmd,
	output ffa_pkg::stat_t                   stat,
	input  wire  [ffa_pkg::OP_W-1:0]         in_op,
	input  wire  [ffa_pkg::LEN_W-1:0]        in_size,
	input  wire                              in_stored,
	input  wire  [ffa_pkg::ADDR_W-1:0]       in_addr,
	input  wire                              cfg_we,
	input  wire  [ffa_pkg::LEN_W-1:0]        cfg_data,
	output logic                             out_vld,
	input  wire                              out_rdy,
	output logic [ffa_pkg::ADDR_W-1:0]       out_addr,
	output logic [ffa_pkg::LEN_W-1:0]        out_grant,
	output logic [ffa_pkg::STATUS_W-1:0]     out_status,
	output logic [ffa_pkg::LEN_W-1:0]        out_used
);
	import ffa_pkg::*;

	localparam int unsigned EIW     = $clog2(MAX_EXTENTS);
	localparam int unsigned CW      = $clog2(MAX_EXTENTS + 1);
	localparam int unsigned HDEPTH  = POOL_WORDS / 2;
	localparam int unsigned HIW     = $clog2(HDEPTH);
	localparam int unsigned QW      = LEN_W + 1;
	localparam int unsigned EW      = ADDR_W + LEN_W;

	logic [EW-1:0]    ext_mem [MAX_EXTENTS];
	logic [LEN_W-1:0] hdr_mem [HDEPTH];

	// item registers
	logic [OP_W-1:0]   op_q;
	logic              st_q;
	logic [QW-1:0]     n_q;
	logic [ADDR_W-1:0] f_q;
	logic [LEN_W-1:0]  rlen_q;

	// table state
	logic [CW-1:0]     count_q;
	logic [LEN_W-1:0]  bump_q;
	logic [LEN_W-1:0]  used_q;
	logic [LEN_W-1:0]  pool_q;

	// read pipe
	logic [CW-1:0]     ptr_q;
	logic [EIW-1:0]    rd_addr;
	logic              vld_s1;
	logic [EIW-1:0]    idx_s1;
	logic [EW-1:0]     ent_s1;
	logic [ADDR_W-1:0] ent_start;
	logic [LEN_W-1:0]  ent_len;
	logic [LEN_W-1:0]  hdr_s1;

	// walk results
	logic              hit_q;
	logic [EIW-1:0]    hit_idx_q;
	logic [ADDR_W-1:0] hit_start_q;
	logic [LEN_W-1:0]  hit_len_q;
	logic              has_lo_q;
	logic [EIW-1:0]    lo_idx_q;
	logic [ADDR_W-1:0] lo_start_q;
	logic [LEN_W-1:0]  lo_len_q;

	logic [QW-1:0]       q_q;
	logic [LEN_W-1:0]    grant_q;
	logic [STATUS_W-1:0] status_q;

	logic              stop_c;
	logic [CW-1:0]     pos;
	logic              whole;
	logic [LEN_W-1:0]  rem_len;
	logic [LEN_W-1:0]  limit;
	logic [LEN_W-1:0]  avail;
	logic              fit;
	logic              join_lo;
	logic              join_hi;
	logic              full;
	logic              wr_en;
	logic [EIW-1:0]    wr_addr;
	logic [EW-1:0]     wr_data;
	logic [QW-1:0]     n_pre;
	logic [ADDR_W-1:0] f_pre;
	logic [31:0]       hq_wide;
	logic [31:0]       hf_wide;
	logic [HIW-1:0]    hq_idx;
	logic [HIW-1:0]    hf_idx;
	logic [LEN_W-1:0]  used_new;
	logic [ADDR_W-1:0] addr_res;

	assign ent_start = ent_s1[EW-1:LEN_W];
	assign ent_len   = ent_s1[LEN_W-1:0];

	assign rd_addr = cmd.ptr_dec ? EIW'(ptr_q - 1'b1) : ptr_q[EIW-1:0];

	assign n_pre = QW'(in_size) + QW'(in_stored);
	assign f_pre = in_stored ? ADDR_W'(in_addr - 1'b1) : in_addr;

	assign hq_wide = 32'(q_q >> 1);
	assign hf_wide = 32'(f_q >> 1);
	assign hq_idx  = hq_wide[HIW-1:0];
	assign hf_idx  = hf_wide[HIW-1:0];

	always_comb begin
		if (op_q == OP_RELEASE) begin
			stop_c = (idx_s1 == '0) ? (f_q < ent_start) : (ent_start >= f_q);
		end else begin
			stop_c = {1'b0, ent_len} >= n_q;
		end
	end

	assign pos     = has_lo_q ? CW'(lo_idx_q) + 1'b1 : '0;
	assign rem_len = LEN_W'({1'b0, hit_len_q} - n_q);
	assign whole   = ({1'b0, hit_len_q} == n_q)
		|| (st_q && ({1'b0, rem_len} <= QW'(2)));
	assign limit   = (32'(pool_q) < 32'(POOL_WORDS)) ? pool_q : LEN_W'(POOL_WORDS);
	assign avail   = (limit > bump_q) ? limit - bump_q : '0;
	assign fit     = n_q <= {1'b0, avail};
	assign join_lo = has_lo_q && (QW'(lo_start_q) + QW'(lo_len_q) == QW'(f_q));
	assign join_hi = hit_q && (QW'(f_q) + QW'(rlen_q) == QW'(hit_start_q));
	assign full    = count_q >= CW'(MAX_EXTENTS);

	always_comb begin
		stat          = '0;
		stat.op       = (cmd.load) ? in_op[0] : op_q[0];
		stat.stored   = (cmd.load) ? in_stored : st_q;
		stat.vld_s1   = vld_s1;
		stat.stop     = vld_s1 && stop_c;
		stat.more_up  = ptr_q < count_q;
		stat.more_dn  = ptr_q > pos;
		stat.hit      = hit_q;
		stat.whole    = whole;
		stat.oom      = !hit_q && !fit;
		stat.join_lo  = join_lo;
		stat.join_hi  = join_hi;
		stat.full     = full;
		stat.out_busy = out_vld && !out_rdy;
	end

	// table write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		if (cmd.rem_wr) begin
			wr_en   = 1'b1;
			wr_addr = EIW'(idx_s1 - 1'b1);
			wr_data = ent_s1;
		end else if (cmd.ins_wr) begin
			wr_en   = 1'b1;
			wr_addr = EIW'(idx_s1 + 1'b1);
			wr_data = ent_s1;
		end else if (cmd.ins_fin) begin
			wr_en   = 1'b1;
			wr_addr = pos[EIW-1:0];
			wr_data = {f_q, rlen_q};
		end else if (cmd.alc_dec && hit_q && !whole) begin
			wr_en   = 1'b1;
			wr_addr = hit_idx_q;
			wr_data = {hit_start_q, rem_len};
		end else if (cmd.rel_dec && join_lo) begin
			wr_en   = 1'b1;
			wr_addr = lo_idx_q;
			wr_data = {lo_start_q, sat_len((LEN_W+2)'(lo_len_q) + (LEN_W+2)'(rlen_q)
				+ (join_hi ? (LEN_W+2)'(hit_len_q) : '0))};
		end else if (cmd.rel_dec && join_hi) begin
			wr_en   = 1'b1;
			wr_addr = hit_idx_q;
			wr_data = {f_q, sat_len((LEN_W+2)'(hit_len_q) + (LEN_W+2)'(rlen_q))};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			ent_s1 <= ext_mem[rd_addr];
			idx_s1 <= rd_addr;
		end
		if (wr_en) begin
			ext_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hdr_rd) begin
			hdr_s1 <= hdr_mem[hf_idx];
		end
		if (cmd.hdr_wr) begin
			hdr_mem[hq_idx] <= grant_q;
		end
	end

	always_comb begin
		used_new = used_q;
		if (op_q == OP_RELEASE) begin
			if (status_q == ST_OK) begin
				used_new = (used_q > rlen_q) ? used_q - rlen_q : '0;
			end
		end else if (status_q == ST_OK) begin
			used_new = sat_len((LEN_W+2)'(used_q) + (LEN_W+2)'(grant_q));
		end
		addr_res = st_q ? ADDR_W'(q_q + 1'b1) : q_q[ADDR_W-1:0];
	end

	// item and walk payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q        <= in_op;
			st_q        <= in_stored;
			n_q         <= n_pre + QW'(n_pre[0]);
			f_q         <= f_pre;
			rlen_q      <= sat_len((LEN_W+2)'(in_size) + (LEN_W+2)'(in_size[0]));
			hit_q       <= 1'b0;
			has_lo_q    <= 1'b0;
			status_q    <= ST_OK;
		end
		if (cmd.hdr_lat) begin
			rlen_q <= hdr_s1;
		end
		if (cmd.scan && vld_s1) begin
			if (stop_c) begin
				hit_q       <= 1'b1;
				hit_idx_q   <= idx_s1;
				hit_start_q <= ent_start;
				hit_len_q   <= ent_len;
			end else begin
				has_lo_q   <= 1'b1;
				lo_idx_q   <= idx_s1;
				lo_start_q <= ent_start;
				lo_len_q   <= ent_len;
			end
		end
		if (cmd.alc_dec) begin
			if (hit_q) begin
				q_q     <= whole ? QW'(hit_start_q) : QW'(hit_start_q) + QW'(rem_len);
				grant_q <= whole ? hit_len_q : LEN_W'(n_q);
			end else begin
				q_q     <= QW'(bump_q);
				grant_q <= fit ? LEN_W'(n_q) : '0;
			end
			status_q <= (!hit_q && !fit) ? ST_OOM : ST_OK;
		end
		if (cmd.rel_dec) begin
			status_q <= (!join_lo && !join_hi && full) ? ST_FULL : ST_OK;
		end
		if (cmd.finish) begin
			out_addr   <= (op_q == OP_RELEASE || status_q != ST_OK) ? '0 : addr_res;
			out_grant  <= (op_q == OP_RELEASE) ? rlen_q : grant_q;
			out_status <= status_q;
			out_used   <= used_new;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			bump_q  <= '0;
			used_q  <= '0;
			pool_q  <= POOL_RESET;
			ptr_q   <= '0;
			vld_s1  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd_en;
			if (cfg_we) begin
				pool_q <= cfg_data;
			end
			if (cmd.load) begin
				ptr_q <= '0;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + 1'b1;
			end else if (cmd.ptr_dec) begin
				ptr_q <= ptr_q - 1'b1;
			end else if (cmd.alc_dec) begin
				ptr_q <= CW'(hit_idx_q) + 1'b1;
			end else if (cmd.rel_dec) begin
				ptr_q <= (join_lo && join_hi) ? CW'(hit_idx_q) + 1'b1 : count_q;
			end
			if (cmd.alc_dec && !hit_q && fit) begin
				bump_q <= bump_q + LEN_W'(n_q);
			end
			if (cmd.cnt_dec) begin
				count_q <= count_q - 1'b1;
			end else if (cmd.ins_fin) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.finish) begin
				used_q  <= used_new;
				out_vld <= 1'b1;
			end else if (out_rdy) begin
				out_vld <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

### design/first_fit_free_list_allocator_unit.sv
// first-fit word heap: allocate or release one block per transaction, one result each
// sequence: the walk to the stopping entry, then, where an entry is removed or inserted, a shift
//   over the rest of the table, one entry per cycle
// flow: one transaction at a time, the next accepted once the result is loaded;
//   a new result is not loaded while the last one still waits on m_tready
// reset: arst_n clears count, bump pointer and usage, pool size back to 65536; no table clearing
`default_nettype none
module first_fit_free_list_allocator_unit #(
	parameter int unsigned POOL_WORDS  = ffa_pkg::POOL_WORDS_DEF,
	parameter int unsigned MAX_EXTENTS = ffa_pkg::MAX_EXTENTS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	// request stream
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,  // size_words[16:0], address[32:17], zero pad
	input  wire  [1:0]  s_tuser,  // opcode[0], use_stored_size[1]
	// result stream
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [55:0] m_tdata,  // block_address[15:0], granted_words[32:16], used_words[49:33]
	output logic [1:0]  m_tuser,  // status[1:0]
	// pool size register
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [16:0] cfg_data
);
	import ffa_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	logic [ADDR_W-1:0]   res_addr;
	logic [LEN_W-1:0]    res_grant;
	logic [STATUS_W-1:0] res_status;
	logic [LEN_W-1:0]    res_used;

	// the user must write the register only while idle; the block does not enforce this, so always ready
	assign cfg_ready = 1'b1;

	// sequencer: walk, shift and commit steps
	ffa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// free table, header store, counters and output register
	ffa_dp #(
		.POOL_WORDS  (POOL_WORDS),
		.MAX_EXTENTS (MAX_EXTENTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_op      (s_tuser[0]),
		.in_size    (s_tdata[16:0]),
		.in_stored  (s_tuser[1]),
		.in_addr    (s_tdata[32:17]),
		.cfg_we     (cfg_valid),
		.cfg_data   (cfg_data),
		.out_vld    (m_tvalid),
		.out_rdy    (m_tready),
		.out_addr   (res_addr),
		.out_grant  (res_grant),
		.out_status (res_status),
		.out_used   (res_used)
	);

	// result packing, zero pad at the top
	assign m_tdata = {6'b0, res_used, res_grant, res_addr};
	assign m_tuser = res_status;

endmodule
`default_nettype wire
